### sv/appc_pkg.sv
// Shared types, register map and the per-pixel photon decision for the photon counter.
`timescale 1ns / 1ps

package appc_pkg;

    localparam int DEF_MAX_PANEL_WIDTH  = 1024;
    localparam int DEF_MAX_PANEL_HEIGHT = 1024;

    localparam int FRAC_W   = 12;
    localparam int WHOLE_W  = 16;
    localparam int INT_W    = 20;
    localparam int INV_W    = 24;
    localparam int SUM_W    = 13;
    localparam int SIZE_W   = 11;
    localparam int POS_W    = 10;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int PROD_W   = INT_W - 1 + INV_W;

    localparam int RES_FIFO_DEPTH = 8;

    localparam logic [2:0] REG_PANEL_WIDTH        = 3'd0;
    localparam logic [2:0] REG_PANEL_HEIGHT       = 3'd1;
    localparam logic [2:0] REG_INVERSE_ADU        = 3'd2;
    localparam logic [2:0] REG_SEED_THRESHOLD     = 3'd3;
    localparam logic [2:0] REG_COMBINED_THRESHOLD = 3'd4;

    localparam logic [SIZE_W-1:0] RST_PANEL_WIDTH   = 11'd128;
    localparam logic [SIZE_W-1:0] RST_PANEL_HEIGHT  = 11'd512;
    localparam logic [INV_W-1:0]  RST_INVERSE_ADU   = 24'd1048576;
    localparam logic [FRAC_W-1:0] RST_SEED          = 12'd1024;
    localparam logic [SUM_W-1:0]  RST_COMBINED      = 13'd4096;

    typedef struct packed {
        logic [FRAC_W-1:0]  frac;
        logic [FRAC_W-1:0]  second;
        logic [WHOLE_W-1:0] whole;
    } line_word_t;

    typedef struct packed {
        logic [WHOLE_W-1:0] count;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   column;
        logic               last;
    } result_t;

    // Add one photon when the own fraction reaches the seed threshold, the own fraction plus the
    // largest present neighbor fraction reaches the combined threshold and the count is not saturated.
    function automatic logic [WHOLE_W-1:0] photon_decide(
        input logic [FRAC_W-1:0]  frac,
        input logic [WHOLE_W-1:0] whole,
        input logic hl, input logic [FRAC_W-1:0] l,
        input logic hr, input logic [FRAC_W-1:0] r,
        input logic hu, input logic [FRAC_W-1:0] u,
        input logic hd, input logic [FRAC_W-1:0] d,
        input logic [FRAC_W-1:0] seed,
        input logic [SUM_W-1:0]  comb
    );
        logic [FRAC_W-1:0] big;
        logic [SUM_W-1:0]  sum;
        big = '0;
        if (hl && l > big) big = l;
        if (hr && r > big) big = r;
        if (hu && u > big) big = u;
        if (hd && d > big) big = d;
        sum = {1'b0, frac} + {1'b0, big};
        if (frac >= seed && sum >= comb && whole != {WHOLE_W{1'b1}}) begin
            return whole + WHOLE_W'(1);
        end
        return whole;
    endfunction

endpackage

### sv/adjacent_pixel_photon_counter.sv
// Adjacent-pixel photon counter: one panel in raster order, line store and result queue.
// Throughput: one pixel per cycle while the result queue has room; in the last row of a
//   panel a pixel releases up to three results and the single result port sets the pace.
// Order: a pixel's results leave with the pixel below it (last row: with the next pixel;
//   the last pixel with itself), through the compute register and the result queue.
// Reset (aresetn low, synchronous): registers take their reset values, position returns
//   to row 0 column 0, queue empties; the line store keeps its contents (no clearing pass).
`timescale 1ns / 1ps

module adjacent_pixel_photon_counter
    import appc_pkg::*;
#(
    parameter int MAX_PANEL_WIDTH  = DEF_MAX_PANEL_WIDTH,
    parameter int MAX_PANEL_HEIGHT = DEF_MAX_PANEL_HEIGHT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [INT_W-1:0]   s_intensity,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [WHOLE_W-1:0]        m_photon_count,
    output logic [POS_W-1:0]          m_row,
    output logic [POS_W-1:0]          m_column,
    output logic                      m_last_of_run
);

    localparam int CW = $clog2(MAX_PANEL_WIDTH);
    localparam int SW = CW + 1;
    localparam int RW = (MAX_PANEL_HEIGHT > 1) ? $clog2(MAX_PANEL_HEIGHT) : 1;
    localparam int SH = RW + 1;
    localparam int FP_W = $clog2(RES_FIFO_DEPTH);

    // ---------------- configuration ----------------
    logic [SIZE_W-1:0] pw_reg, ph_reg;
    logic [INV_W-1:0]  inv_reg;
    logic [FRAC_W-1:0] seed_reg;
    logic [SUM_W-1:0]  comb_reg;
    logic              cfg_we;
    logic [2:0]        cfg_idx;
    logic              size_we;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign size_we = cfg_we && (cfg_idx == REG_PANEL_WIDTH || cfg_idx == REG_PANEL_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg   <= RST_PANEL_WIDTH;
            ph_reg   <= RST_PANEL_HEIGHT;
            inv_reg  <= RST_INVERSE_ADU;
            seed_reg <= RST_SEED;
            comb_reg <= RST_COMBINED;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_PANEL_WIDTH:        pw_reg   <= pwdata[SIZE_W-1:0];
                REG_PANEL_HEIGHT:       ph_reg   <= pwdata[SIZE_W-1:0];
                REG_INVERSE_ADU:        inv_reg  <= pwdata[INV_W-1:0];
                REG_SEED_THRESHOLD:     seed_reg <= pwdata[FRAC_W-1:0];
                REG_COMBINED_THRESHOLD: comb_reg <= pwdata[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PANEL_WIDTH:        prdata = PDATA_W'(pw_reg);
            REG_PANEL_HEIGHT:       prdata = PDATA_W'(ph_reg);
            REG_INVERSE_ADU:        prdata = PDATA_W'(inv_reg);
            REG_SEED_THRESHOLD:     prdata = PDATA_W'(seed_reg);
            REG_COMBINED_THRESHOLD: prdata = PDATA_W'(comb_reg);
            default:                prdata = '0;
        endcase
    end

    // clamp sizes to 1..MAX
    logic [12:0]   pw_ext, ph_ext;
    logic [SW-1:0] w_eff;
    logic [SH-1:0] h_eff;

    always_comb begin
        pw_ext = 13'(pw_reg);
        ph_ext = 13'(ph_reg);
        if (pw_ext == 13'd0)                         w_eff = SW'(1);
        else if (pw_ext > 13'(MAX_PANEL_WIDTH))      w_eff = SW'(MAX_PANEL_WIDTH);
        else                                         w_eff = SW'(pw_ext);
        if (ph_ext == 13'd0)                         h_eff = SH'(1);
        else if (ph_ext > 13'(MAX_PANEL_HEIGHT))     h_eff = SH'(MAX_PANEL_HEIGHT);
        else                                         h_eff = SH'(ph_ext);
    end

    // ---------------- position and input register ----------------
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          accept;
    logic          in_col_last, in_row_last;
    logic [SW-1:0] in_colp1;
    logic [CW-1:0] addr_a, addr_b;

    logic                    a_valid_reg;
    logic signed [INT_W-1:0] a_int_reg;
    logic [RW-1:0]           a_row_reg;
    logic [CW-1:0]           a_col_reg, a_colb_reg;
    logic                    a_go;

    logic [FP_W:0]   fifo_cnt_reg;
    assign a_go    = a_valid_reg && (fifo_cnt_reg <= (FP_W+1)'(RES_FIFO_DEPTH - 3));
    assign s_ready = !a_valid_reg || a_go;
    assign accept  = s_valid && s_ready;

    assign in_col_last = SW'(col_reg) == w_eff - SW'(1);
    assign in_row_last = SH'(row_reg) == h_eff - SH'(1);
    assign in_colp1    = SW'(col_reg) + SW'(1);
    assign addr_a      = col_reg;
    assign addr_b      = (in_colp1 < w_eff) ? in_colp1[CW-1:0] : col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || size_we) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (in_col_last) begin
                col_reg <= '0;
                row_reg <= in_row_last ? '0 : row_reg + RW'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_go) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_int_reg  <= s_intensity;
            a_row_reg  <= row_reg;
            a_col_reg  <= col_reg;
            a_colb_reg <= addr_b;
        end
    end

    // ---------------- line store ----------------
    line_word_t    line_mem [0:MAX_PANEL_WIDTH-1];
    line_word_t    rda_q;
    logic [FRAC_W-1:0] rdb_q;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    line_word_t    wr_data;
    logic          ex_we;
    logic [CW-1:0] ex_addr;
    line_word_t    ex_data;
    logic          pend_we_reg;
    logic [CW-1:0] pend_addr_reg;
    line_word_t    pend_data_reg;

    assign wr_en   = pend_we_reg || ex_we;
    assign wr_addr = pend_we_reg ? pend_addr_reg : ex_addr;
    assign wr_data = pend_we_reg ? pend_data_reg : ex_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            rda_q <= line_mem[addr_a];
            rdb_q <= line_mem[addr_b].frac;
        end
    end

    // snoop writes that land after the read was launched
    logic              hita_reg, hitb_reg;
    line_word_t        bypa_reg;
    logic [FRAC_W-1:0] bypb_reg;
    line_word_t        old_a;
    logic [FRAC_W-1:0] old_b;
    logic              pend_hit_a, pend_hit_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hita_reg <= 1'b0;
            hitb_reg <= 1'b0;
        end else if (accept) begin
            hita_reg <= wr_en && wr_addr == addr_a;
            hitb_reg <= wr_en && wr_addr == addr_b;
        end else if (wr_en) begin
            if (wr_addr == a_col_reg)  hita_reg <= 1'b1;
            if (wr_addr == a_colb_reg) hitb_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            bypa_reg <= wr_data;
            bypb_reg <= wr_data.frac;
        end else if (wr_en) begin
            if (wr_addr == a_col_reg)  bypa_reg <= wr_data;
            if (wr_addr == a_colb_reg) bypb_reg <= wr_data.frac;
        end
    end

    // the row-end write lands while the next word is already in the compute register
    assign pend_hit_a = pend_we_reg && pend_addr_reg == a_col_reg;
    assign pend_hit_b = pend_we_reg && pend_addr_reg == a_colb_reg;
    assign old_a = pend_hit_a ? pend_data_reg : (hita_reg ? bypa_reg : rda_q);
    assign old_b = pend_hit_b ? pend_data_reg.frac : (hitb_reg ? bypb_reg : rdb_q);

    // ---------------- compute ----------------
    logic [FRAC_W-1:0]  left_frac_reg, win1_reg, win2_reg;
    logic [WHOLE_W-1:0] left_whole_reg;
    logic [PROD_W-1:0]  prod;
    logic               pos;
    logic [FRAC_W-1:0]  frac;
    logic [WHOLE_W-1:0] whole;
    logic c_pos, c_gt1, r_pos, r_ge2, hr, last_row, last_col;
    logic v1, v2, v3;
    result_t e1, e2, e3;

    assign pos   = !a_int_reg[INT_W-1] && (a_int_reg != '0);
    assign prod  = PROD_W'(a_int_reg[INT_W-2:0]) * PROD_W'(inv_reg);
    assign frac  = pos ? prod[23:12] : '0;
    assign whole = !pos ? '0 : (|prod[PROD_W-1:40]) ? {WHOLE_W{1'b1}} : prod[39:24];

    assign c_pos    = a_col_reg != '0;
    assign c_gt1    = SW'(a_col_reg) > SW'(1);
    assign r_pos    = a_row_reg != '0;
    assign r_ge2    = SH'(a_row_reg) >= SH'(2);
    assign hr       = (SW'(a_col_reg) + SW'(1)) < w_eff;
    assign last_row = SH'(a_row_reg) == h_eff - SH'(1);
    assign last_col = SW'(a_col_reg) == w_eff - SW'(1);

    assign v1 = r_pos;
    assign v2 = last_row && c_pos;
    assign v3 = last_row && last_col;

    always_comb begin
        e1.count  = photon_decide(old_a.frac, old_a.whole, c_pos, win1_reg, hr, old_b,
                                  r_ge2, old_a.second, 1'b1, frac, seed_reg, comb_reg);
        e1.row    = POS_W'(a_row_reg - RW'(1));
        e1.column = POS_W'(a_col_reg);
        e1.last   = !v2 && !v3;
        e2.count  = photon_decide(left_frac_reg, left_whole_reg, c_gt1, win2_reg, 1'b1, frac,
                                  r_pos, win1_reg, 1'b0, '0, seed_reg, comb_reg);
        e2.row    = POS_W'(a_row_reg);
        e2.column = POS_W'(a_col_reg - CW'(1));
        e2.last   = !v3;
        e3.count  = photon_decide(frac, whole, c_pos, left_frac_reg, 1'b0, '0,
                                  r_pos, old_a.frac, 1'b0, '0, seed_reg, comb_reg);
        e3.row    = POS_W'(a_row_reg);
        e3.column = POS_W'(a_col_reg);
        e3.last   = 1'b1;
    end

    // retire the left pixel into the line store; the row end is written the next cycle
    assign ex_we        = a_go && c_pos;
    assign ex_addr      = a_col_reg - CW'(1);
    assign ex_data.frac   = left_frac_reg;
    assign ex_data.second = win1_reg;
    assign ex_data.whole  = left_whole_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_we_reg <= 1'b0;
        end else begin
            pend_we_reg <= a_go && last_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go && last_col) begin
            pend_addr_reg        <= a_col_reg;
            pend_data_reg.frac   <= frac;
            pend_data_reg.second <= old_a.frac;
            pend_data_reg.whole  <= whole;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || size_we) begin
            left_frac_reg  <= '0;
            left_whole_reg <= '0;
        end else if (a_go) begin
            left_frac_reg  <= last_col ? '0 : frac;
            left_whole_reg <= last_col ? '0 : whole;
        end
    end

    // win2 holds the fraction two pixels back in the current row
    always_ff @(posedge aclk) begin
        if (a_go) begin
            win1_reg <= old_a.frac;
            win2_reg <= left_frac_reg;
        end
    end

    // ---------------- result queue ----------------
    result_t         fifo_mem [0:RES_FIFO_DEPTH-1];
    logic [FP_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FP_W:0]   fifo_cnt_next;
    logic [1:0]      npush;
    logic [FP_W-1:0] off2, off3;
    logic            pop;
    result_t         head;

    assign npush = a_go ? (2'(v1) + 2'(v2) + 2'(v3)) : 2'd0;
    assign off2  = FP_W'(v1);
    assign off3  = FP_W'(v1) + FP_W'(v2);
    assign pop   = m_valid && m_ready;
    assign fifo_cnt_next = fifo_cnt_reg + (FP_W+1)'(npush) - (FP_W+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            wr_ptr_reg   <= wr_ptr_reg + FP_W'(npush);
            rd_ptr_reg   <= rd_ptr_reg + FP_W'(pop);
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go) begin
            if (v1) fifo_mem[wr_ptr_reg] <= e1;
            if (v2) fifo_mem[wr_ptr_reg + off2] <= e2;
            if (v3) fifo_mem[wr_ptr_reg + off3] <= e3;
        end
    end

    assign head           = fifo_mem[rd_ptr_reg];
    assign m_valid        = fifo_cnt_reg != '0;
    assign m_photon_count = head.count;
    assign m_row          = head.row;
    assign m_column       = head.column;
    assign m_last_of_run  = head.last;

    // ---------------- assertions ----------------
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pend_we_reg && ex_we))
        else $error("row-end write collides with left-pixel write");

    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= (FP_W+1)'(RES_FIFO_DEPTH))
        else $error("result queue overflow");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> a_valid_reg)
        else $error("accepted word not held in compute register");

    a_row_end_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_go && last_col) |=> pend_we_reg)
        else $error("row end not written to line store");

endmodule

### bench/adjacent_pixel_photon_counter_test.sv
// Self-checking bench for the adjacent-pixel photon counter: directed and random panels, checked per result word.
`timescale 1ns / 1ps

module adjacent_pixel_photon_counter_test;
    import appc_pkg::*;

    localparam int MAX_W = DEF_MAX_PANEL_WIDTH;
    localparam int MAX_H = DEF_MAX_PANEL_HEIGHT;
    localparam int STALL_LIMIT = 2000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [INT_W-1:0] s_intensity = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [WHOLE_W-1:0] m_photon_count;
    logic [POS_W-1:0] m_row, m_column;
    logic m_last_of_run;

    adjacent_pixel_photon_counter i_dut (.*);

    // model of the configuration and the pixel history
    logic [SIZE_W-1:0]  width_reg, height_reg;
    logic [INV_W-1:0]   inv_adu_reg;
    logic [FRAC_W-1:0]  seed_reg;
    logic [SUM_W-1:0]   comb_reg;
    logic [FRAC_W-1:0]  above_frac [MAX_W];
    logic [FRAC_W-1:0]  two_above_frac [MAX_W];
    logic [WHOLE_W-1:0] above_whole [MAX_W];
    logic [FRAC_W-1:0]  left_frac;
    logic [WHOLE_W-1:0] left_whole;
    int unsigned        cur_col, cur_row;

    logic signed [INT_W-1:0] pixel_queue [$];
    result_t                 expected_counts [$];

    bit failed = 1'b0;
    bit no_idle = 1'b0;
    bit in_taken = 1'b0, out_taken = 1'b0;
    int in_gap = 0, out_gap = 0;
    int quiet_cycles = 0;
    int random_pixels = 0;

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [WHOLE_W-1:0] merged_count(
        logic [FRAC_W-1:0] frac, logic [WHOLE_W-1:0] whole,
        bit hl, logic [FRAC_W-1:0] l, bit hr, logic [FRAC_W-1:0] r,
        bit hu, logic [FRAC_W-1:0] u, bit hd, logic [FRAC_W-1:0] d);
        logic [FRAC_W-1:0] top;
        top = '0;
        if (frac < seed_reg) return whole;
        if (hl && l > top) top = l;
        if (hr && r > top) top = r;
        if (hu && u > top) top = u;
        if (hd && d > top) top = d;
        if ({1'b0, frac} + {1'b0, top} >= comb_reg && whole != 16'hFFFF) return whole + 16'd1;
        return whole;
    endfunction

    function automatic void push_count(logic [WHOLE_W-1:0] cnt, int unsigned r, int unsigned c);
        result_t e;
        e.count = cnt;
        e.row = POS_W'(r);
        e.column = POS_W'(c);
        e.last = 1'b0;
        expected_counts = {expected_counts, e};
    endfunction

    // work out the words released by one pixel and advance the history
    function automatic void count_pixel(logic [INT_W-1:0] raw);
        int unsigned w, h, r, c, n;
        logic [43:0] prod;
        logic [FRAC_W-1:0] frac;
        logic [WHOLE_W-1:0] whole;
        w = width_reg < 1 ? 1 : (width_reg > MAX_W ? MAX_W : width_reg);
        h = height_reg < 1 ? 1 : (height_reg > MAX_H ? MAX_H : height_reg);
        r = cur_row >= h ? 0 : cur_row;
        c = cur_col >= w ? 0 : cur_col;
        frac = '0;
        whole = '0;
        n = expected_counts.size();
        if (raw != 0 && !raw[INT_W-1]) begin
            prod = 44'(raw) * 44'(inv_adu_reg);
            whole = prod[43:24] > 20'hFFFF ? 16'hFFFF : prod[39:24];
            frac = prod[23:12];
        end
        if (r > 0)
            push_count(merged_count(above_frac[c], above_whole[c],
                c > 0, c > 0 ? above_frac[c-1] : '0,
                c + 1 < w, c + 1 < w ? above_frac[c+1] : '0,
                r >= 2, two_above_frac[c], 1'b1, frac), r - 1, c);
        if (r == h - 1 && c > 0)
            push_count(merged_count(left_frac, left_whole,
                c > 1, c > 1 ? above_frac[c-2] : '0, 1'b1, frac,
                r > 0, above_frac[c-1], 1'b0, '0), r, c - 1);
        if (r == h - 1 && c == w - 1)
            push_count(merged_count(frac, whole, c > 0, left_frac, 1'b0, '0,
                r > 0, above_frac[c], 1'b0, '0), r, c);
        if (expected_counts.size() > n) expected_counts[$].last = 1'b1;
        if (c > 0) begin
            two_above_frac[c-1] = above_frac[c-1];
            above_frac[c-1] = left_frac;
            above_whole[c-1] = left_whole;
        end
        if (c == w - 1) begin
            two_above_frac[c] = above_frac[c];
            above_frac[c] = frac;
            above_whole[c] = whole;
            left_frac = '0;
            left_whole = '0;
            cur_col = 0;
            cur_row = r + 1 >= h ? 0 : r + 1;
        end else begin
            left_frac = frac;
            left_whole = whole;
            cur_col = c + 1;
            cur_row = r;
        end
    endfunction

    initial begin
        forever #6 aclk = ~aclk;
    end

    // input driver
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                s_intensity <= pixel_queue.pop_front();
                s_valid <= 1'b1;
                in_gap <= draw_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side stall
    always @(negedge aclk) begin
        int g;
        g = out_taken ? draw_gap() : out_gap;
        if (g > 0) begin
            m_ready <= 1'b0;
            out_gap <= g - 1;
        end else begin
            m_ready <= 1'b1;
            out_gap <= 0;
        end
    end

    // monitor, predictor hookup and watchdog
    always @(posedge aclk) begin
        result_t e;
        in_taken <= s_valid && s_ready;
        out_taken <= m_valid && m_ready;
        if (aresetn && s_valid && s_ready) count_pixel(s_intensity);
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected word count=%0d row=%0d col=%0d last=%0d", $time,
                    m_photon_count, m_row, m_column, m_last_of_run);
                failed = 1'b1;
            end else begin
                e = expected_counts.pop_front();
                if (e.count !== m_photon_count || e.row !== m_row || e.column !== m_column
                        || e.last !== m_last_of_run) begin
                    $display("%0t: mismatch expected count=%0d row=%0d col=%0d last=%0d",
                        $time, e.count, e.row, e.column, e.last);
                    $display("%0t:          actual   count=%0d row=%0d col=%0d last=%0d",
                        $time, m_photon_count, m_row, m_column, m_last_of_run);
                    failed = 1'b1;
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [PDATA_W-1:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PANEL_WIDTH:        width_reg = val[SIZE_W-1:0];
            REG_PANEL_HEIGHT:       height_reg = val[SIZE_W-1:0];
            REG_INVERSE_ADU:        inv_adu_reg = val[INV_W-1:0];
            REG_SEED_THRESHOLD:     seed_reg = val[FRAC_W-1:0];
            REG_COMBINED_THRESHOLD: comb_reg = val[SUM_W-1:0];
            default: ;
        endcase
        if (idx == REG_PANEL_WIDTH || idx == REG_PANEL_HEIGHT) begin
            cur_col = 0;
            cur_row = 0;
            left_frac = '0;
            left_whole = '0;
        end
    endtask

    task automatic set_config(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                              logic [INV_W-1:0] inv, logic [FRAC_W-1:0] seed,
                              logic [SUM_W-1:0] comb);
        write_reg(REG_PANEL_WIDTH, w);
        write_reg(REG_PANEL_HEIGHT, h);
        write_reg(REG_INVERSE_ADU, inv);
        write_reg(REG_SEED_THRESHOLD, seed);
        write_reg(REG_COMBINED_THRESHOLD, comb);
    endtask

    // hold until every pixel is in and every word is out, then let the pipe settle
    task automatic drain();
        do @(posedge aclk); while (pixel_queue.size() > 0 || s_valid
                                   || expected_counts.size() > 0);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [INT_W-1:0] pick_intensity();
        case ($urandom_range(0, 4))
            0: return INT_W'($urandom);
            1: return INT_W'($urandom_range(0, 255));
            2: return INT_W'($urandom_range(0, 65535));
            3: return -INT_W'($urandom_range(0, 64));
            default: return INT_W'($urandom_range(1, 32));
        endcase
    endfunction

    task automatic queue_panels(int unsigned w, int unsigned h, int unsigned panels);
        repeat (panels * w * h) pixel_queue = {pixel_queue, pick_intensity()};
        random_pixels += panels * w * h;
    endtask

    initial begin
        int unsigned w, h;
        width_reg = RST_PANEL_WIDTH;
        height_reg = RST_PANEL_HEIGHT;
        inv_adu_reg = RST_INVERSE_ADU;
        seed_reg = RST_SEED;
        comb_reg = RST_COMBINED;
        cur_col = 0;
        cur_row = 0;
        left_frac = '0;
        left_whole = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes of intensity, full scale factor, zero thresholds
        set_config(4, 3, 24'hFFFFFF, 12'd0, 13'd0);
        foreach (pixel_queue[i]) ;
        pixel_queue = '{20'sd524287, -20'sd524288, 20'sd0, 20'sd1, -20'sd1, 20'sd16,
                        20'sd524287, 20'sd100, 20'sd8, 20'sd262144, 20'sd3, 20'sd7};
        drain();
        // directed: scale factor 1/16, default thresholds, then maximal thresholds, then zero scale
        set_config(3, 2, 24'd1048576, 12'd1024, 13'd4096);
        pixel_queue = '{20'sd24, 20'sd12, 20'sd4, 20'sd31, 20'sd17, 20'sd2};
        drain();
        set_config(2, 2, 24'd1048576, 12'hFFF, 13'h1FFF);
        pixel_queue = '{20'sd15, 20'sd31, 20'sd47, 20'sd15};
        drain();
        write_reg(REG_INVERSE_ADU, 24'd0);
        pixel_queue = '{20'sd524287, 20'sd1000, 20'sd5, 20'sd77};
        drain();

        // size extremes: zero width and zero height clamp to one
        no_idle = 1'b1;
        set_config(0, 4, 24'd1048576, 12'd512, 13'd3000);
        queue_panels(1, 4, 1);
        drain();
        no_idle = 1'b0;
        set_config(3, 0, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 4095),
                   $urandom_range(0, 8191));
        queue_panels(3, 1, 1);
        drain();

        random_pixels = 0;
        while (random_pixels < 230) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: set_config(w, h, 24'd1048576, $urandom_range(0, 4095),
                              $urandom_range(0, 8191));
                1: set_config(w, h, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 2048),
                              $urandom_range(0, 4096));
                default: set_config(w, h, $urandom_range(1 << 18, 1 << 22),
                              $urandom_range(0, 4095), $urandom_range(0, 8191));
            endcase
            queue_panels(w, h, $urandom_range(1, 2));
            drain();
        end

        if (failed || expected_counts.size() > 0) begin
            $display("TEST FAILED");
        end else begin
            $display("TEST PASSED");
        end
        $finish;
    end

endmodule

### adjacent_pixel_photon_counter.f
sv/appc_pkg.sv
sv/adjacent_pixel_photon_counter.sv
bench/adjacent_pixel_photon_counter_test.sv
